FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the PLT stub resolver.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define APSR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define APSR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define APSR_ASSERT(label, clk, rst_n, prop, msg)
`define APSR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/apsr_pkg.sv
// Shared types, constants and a helper function of the PLT stub resolver.
// No dependencies.
package apsr_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [31:0] PAT_MASK    = 32'hffff_f000;
    localparam logic [31:0] PAT_ADD_PC  = 32'he28f_c000;
    localparam logic [31:0] PAT_ADD_IP  = 32'he28c_c000;
    localparam logic [31:0] PAT_LDR_PC  = 32'he5bc_f000;
    localparam logic [31:0] PC_BIAS     = 32'd8;
    localparam logic [7:0]  JUMP_SLOT_RESET = 8'd22;

    localparam int OFFSET_W = 32;
    localparam int SYMBOL_W = 24;
    localparam int ENTRY_W  = OFFSET_W + SYMBOL_W;

    typedef enum logic [2:0] {
        ST_STORED        = 3'd0,
        ST_OTHER_TYPE    = 3'd1,
        ST_OUT_OF_RANGE  = 3'd2,
        ST_TABLE_FULL    = 3'd3,
        ST_WORD_CONSUMED = 3'd4,
        ST_STUB_FOUND    = 3'd5,
        ST_STUB_UNKNOWN  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CFG_PLT_BASE     = 2'd0,
        CFG_JUMP_SLOT    = 2'd1,
        CFG_SYMBOL_COUNT = 2'd2
    } cfg_idx_t;

    // ARM data-processing immediate: 8-bit value rotated right by twice the rotate field
    function automatic logic [31:0] rot_imm(input logic [31:0] word);
        logic [63:0] dbl;
        logic [4:0]  r;
        r   = {word[11:8], 1'b0};
        dbl = {24'd0, word[7:0], 24'd0, word[7:0]};
        return dbl[r +: 32];
    endfunction

endpackage

FILE: rtl/arm_plt_stub_resolver.sv
// ARM PLT stub resolver: relocation table in one RAM, three-word stub matcher.
// Depends on apsr_pkg, apsr_ram and assert_macros.svh.
// One beat at a time: the input is ready only in the idle state. A table insert or stub lookup
// is a linear scan over the entries, one RAM read a cycle, and a rejected relocation or a
// plain PLT word skips the scan; a stalled result beat holds the block in its emit state
// and blocks the input.
// Reset (rst_n, async): table empty, matcher at start, word index 0, registers at defaults.
module arm_plt_stub_resolver #(
    parameter int TABLE_DEPTH = apsr_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // reloc_offset[31:0], reloc_info[63:32], instr_word[95:64]
    input  logic        s_tuser,   // kind[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // symbol_index[23:0], stub_address[55:24],
                                   // slot_offset[87:56], zero[95:88]
    output logic [2:0]  m_tuser,   // status[2:0]
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

`include "assert_macros.svh"

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;
    typedef enum logic [1:0] {STEP_START, STEP_ADD_IP, STEP_LDR} step_t;

    // input fields
    logic        kind;
    logic [31:0] reloc_offset;
    logic [31:0] reloc_info;
    logic [31:0] instr_word;

    assign kind         = s_tuser;
    assign reloc_offset = s_tdata[31:0];
    assign reloc_info   = s_tdata[63:32];
    assign instr_word   = s_tdata[95:64];

    state_t                state_reg, state_next;
    step_t                 step_reg, step_next;
    logic [31:0]           plt_base_reg, plt_base_next;
    logic [7:0]            jump_slot_reg, jump_slot_next;
    logic [23:0]           symbol_count_reg, symbol_count_next;
    logic [CW-1:0]         entry_count_reg, entry_count_next;
    logic [29:0]           word_index_reg, word_index_next;
    logic [31:0]           pending_addr_reg, pending_addr_next;
    logic [31:0]           partial_sum_reg, partial_sum_next;
    logic                  op_lookup_reg, op_lookup_next;
    logic [31:0]           key_reg, key_next;
    logic [23:0]           sym_in_reg, sym_in_next;
    logic [CW-1:0]         rd_idx_reg, rd_idx_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [AW-1:0]         pend_addr_reg, pend_addr_next;
    apsr_pkg::status_t     res_status_reg, res_status_next;
    logic [23:0]           res_sym_reg, res_sym_next;
    logic [31:0]           res_addr_reg, res_addr_next;
    logic [31:0]           res_off_reg, res_off_next;
    logic                  m_valid_reg, m_valid_next;
    apsr_pkg::status_t     m_status_reg, m_status_next;
    logic [23:0]           m_sym_reg, m_sym_next;
    logic [31:0]           m_addr_reg, m_addr_next;
    logic [31:0]           m_off_reg, m_off_next;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [apsr_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [apsr_pkg::ENTRY_W-1:0]  ram_rdata;
    logic                          ram_append;
    logic                          hit;
    logic                          out_free;
    logic [31:0]                   word_addr;
    logic [31:0]                   masked_word;

    apsr_ram #(
        .WIDTH (apsr_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_status_reg;
    assign m_tdata   = {8'd0, m_off_reg, m_addr_reg, m_sym_reg};

    assign out_free    = !m_valid_reg || m_tready;
    assign word_addr   = plt_base_reg + {word_index_reg, 2'b00};
    assign masked_word = instr_word & apsr_pkg::PAT_MASK;
    assign hit         = pend_valid_reg && (ram_rdata[31:0] == key_reg);
    assign ram_raddr   = rd_idx_reg[AW-1:0];

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        plt_base_next     = plt_base_reg;
        jump_slot_next    = jump_slot_reg;
        symbol_count_next = symbol_count_reg;
        entry_count_next  = entry_count_reg;
        word_index_next   = word_index_reg;
        pending_addr_next = pending_addr_reg;
        partial_sum_next  = partial_sum_reg;
        op_lookup_next    = op_lookup_reg;
        key_next          = key_reg;
        sym_in_next       = sym_in_reg;
        rd_idx_next       = rd_idx_reg;
        pend_valid_next   = pend_valid_reg;
        pend_addr_next    = pend_addr_reg;
        res_status_next   = res_status_reg;
        res_sym_next      = res_sym_reg;
        res_addr_next     = res_addr_reg;
        res_off_next      = res_off_reg;
        m_valid_next      = m_valid_reg;
        m_status_next     = m_status_reg;
        m_sym_next        = m_sym_reg;
        m_addr_next       = m_addr_reg;
        m_off_next        = m_off_reg;
        ram_we            = 1'b0;
        ram_waddr         = '0;
        ram_wdata         = '0;
        ram_append        = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                apsr_pkg::CFG_PLT_BASE:     plt_base_next     = cfg_data;
                apsr_pkg::CFG_JUMP_SLOT:    jump_slot_next    = cfg_data[7:0];
                apsr_pkg::CFG_SYMBOL_COUNT: symbol_count_next = cfg_data[23:0];
                default:                    ;
            endcase
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_sym_next  = '0;
                    res_addr_next = '0;
                    res_off_next  = '0;
                    state_next    = S_EMIT;
                    if (!kind)
                    begin
                        if (reloc_info[7:0] != jump_slot_reg)
                        begin
                            res_status_next = apsr_pkg::ST_OTHER_TYPE;
                        end
                        else if (reloc_info[31:8] >= symbol_count_reg)
                        begin
                            res_status_next = apsr_pkg::ST_OUT_OF_RANGE;
                        end
                        else
                        begin
                            key_next        = reloc_offset;
                            sym_in_next     = reloc_info[31:8];
                            op_lookup_next  = 1'b0;
                            rd_idx_next     = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                    end
                    else
                    begin
                        word_index_next = word_index_reg + 30'd1;
                        res_status_next = apsr_pkg::ST_WORD_CONSUMED;
                        // a word off the pattern drops back to start and is not retried
                        case (step_reg)
                            STEP_START:
                            begin
                                if (masked_word == apsr_pkg::PAT_ADD_PC)
                                begin
                                    pending_addr_next = word_addr;
                                    partial_sum_next  = apsr_pkg::rot_imm(instr_word)
                                                      + word_addr + apsr_pkg::PC_BIAS;
                                    step_next         = STEP_ADD_IP;
                                end
                            end
                            STEP_ADD_IP:
                            begin
                                if (masked_word == apsr_pkg::PAT_ADD_IP)
                                begin
                                    partial_sum_next = partial_sum_reg
                                                     + apsr_pkg::rot_imm(instr_word);
                                    step_next        = STEP_LDR;
                                end
                                else
                                begin
                                    step_next = STEP_START;
                                end
                            end
                            default:
                            begin
                                if (masked_word == apsr_pkg::PAT_LDR_PC)
                                begin
                                    key_next        = partial_sum_reg
                                                    + {20'd0, instr_word[11:0]};
                                    op_lookup_next  = 1'b1;
                                    rd_idx_next     = '0;
                                    pend_valid_next = 1'b0;
                                    state_next      = S_SCAN;
                                end
                                step_next = STEP_START;
                            end
                        endcase
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = S_EMIT;
                    if (op_lookup_reg)
                    begin
                        res_status_next = apsr_pkg::ST_STUB_FOUND;
                        res_sym_next    = ram_rdata[apsr_pkg::ENTRY_W-1:32];
                        res_addr_next   = pending_addr_reg;
                        res_off_next    = key_reg;
                    end
                    else
                    begin
                        // overwrite the symbol of the matching entry
                        ram_we          = 1'b1;
                        ram_waddr       = pend_addr_reg;
                        ram_wdata       = {sym_in_reg, key_reg};
                        res_status_next = apsr_pkg::ST_STORED;
                    end
                end
                else if (rd_idx_reg < entry_count_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_addr_next  = rd_idx_reg[AW-1:0];
                    rd_idx_next     = rd_idx_reg + CW'(1);
                end
                else if (pend_valid_reg)
                begin
                    // drain the last read
                    pend_valid_next = 1'b0;
                end
                else
                begin
                    state_next = S_EMIT;
                    if (op_lookup_reg)
                    begin
                        res_status_next = apsr_pkg::ST_STUB_UNKNOWN;
                        res_addr_next   = pending_addr_reg;
                        res_off_next    = key_reg;
                    end
                    else if (entry_count_reg < DEPTH_C)
                    begin
                        ram_we           = 1'b1;
                        ram_append       = 1'b1;
                        ram_waddr        = entry_count_reg[AW-1:0];
                        ram_wdata        = {sym_in_reg, key_reg};
                        entry_count_next = entry_count_reg + CW'(1);
                        res_status_next  = apsr_pkg::ST_STORED;
                    end
                    else
                    begin
                        res_status_next = apsr_pkg::ST_TABLE_FULL;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_sym_next    = res_sym_reg;
                    m_addr_next   = res_addr_reg;
                    m_off_next    = res_off_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= STEP_START;
            plt_base_reg     <= '0;
            jump_slot_reg    <= apsr_pkg::JUMP_SLOT_RESET;
            symbol_count_reg <= '0;
            entry_count_reg  <= '0;
            word_index_reg   <= '0;
            pending_addr_reg <= '0;
            partial_sum_reg  <= '0;
            op_lookup_reg    <= 1'b0;
            key_reg          <= '0;
            sym_in_reg       <= '0;
            rd_idx_reg       <= '0;
            pend_valid_reg   <= 1'b0;
            pend_addr_reg    <= '0;
            res_status_reg   <= apsr_pkg::ST_STORED;
            res_sym_reg      <= '0;
            res_addr_reg     <= '0;
            res_off_reg      <= '0;
            m_valid_reg      <= 1'b0;
            m_status_reg     <= apsr_pkg::ST_STORED;
            m_sym_reg        <= '0;
            m_addr_reg       <= '0;
            m_off_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            plt_base_reg     <= plt_base_next;
            jump_slot_reg    <= jump_slot_next;
            symbol_count_reg <= symbol_count_next;
            entry_count_reg  <= entry_count_next;
            word_index_reg   <= word_index_next;
            pending_addr_reg <= pending_addr_next;
            partial_sum_reg  <= partial_sum_next;
            op_lookup_reg    <= op_lookup_next;
            key_reg          <= key_next;
            sym_in_reg       <= sym_in_next;
            rd_idx_reg       <= rd_idx_next;
            pend_valid_reg   <= pend_valid_next;
            pend_addr_reg    <= pend_addr_next;
            res_status_reg   <= res_status_next;
            res_sym_reg      <= res_sym_next;
            res_addr_reg     <= res_addr_next;
            res_off_reg      <= res_off_next;
            m_valid_reg      <= m_valid_next;
            m_status_reg     <= m_status_next;
            m_sym_reg        <= m_sym_next;
            m_addr_reg       <= m_addr_next;
            m_off_reg        <= m_off_next;
        end
    end

    `APSR_ASSERT(a_count_bound, clk, rst_n, entry_count_reg <= DEPTH_C, "entry count past table depth")
    `APSR_ASSERT(a_accept_busy, clk, rst_n, (s_tvalid && s_tready) |=> (state_reg != S_IDLE), "accepted beat left no work")
    `APSR_ASSERT(a_write_insert, clk, rst_n, ram_we |-> (state_reg == S_SCAN && !op_lookup_reg), "table written outside an insert")
    `APSR_ASSERT(a_append_count, clk, rst_n, ram_append |=> (entry_count_reg == $past(entry_count_reg) + CW'(1)), "append did not bump entry count")

endmodule

FILE: rtl/apsr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module apsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: bench/arm_plt_stub_resolver_checker.sv
// Scoreboard for the PLT stub resolver: tracks the relocation table and the stub matcher
// from the input and configuration beats, and compares every result beat in order.
// Depends on apsr_pkg for the status and register codes and the instruction patterns.
module arm_plt_stub_resolver_checker #(
    parameter int TABLE_DEPTH = apsr_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,   // reloc_offset[31:0], reloc_info[63:32], instr_word[95:64]
    input  logic        s_tuser,   // kind[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,   // symbol_index[23:0], stub_address[55:24],
                                   // slot_offset[87:56], zero[95:88]
    input  logic [2:0]  m_tuser,   // status[2:0]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int unsigned mismatches,
    output int unsigned reports_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_PLT_WORD = 1'b1;

    typedef enum logic [1:0] {
        SEEK_ADD_PC,
        SEEK_ADD_IP,
        SEEK_LDR_PC
    } stub_step_t;

    typedef struct packed {
        apsr_pkg::status_t status;
        logic [23:0]       symbol;
        logic [31:0]       stub_addr;
        logic [31:0]       slot_off;
    } stub_report_t;

    stub_report_t expected_reports[$];

    logic [31:0] tbl_off [TABLE_DEPTH];
    logic [23:0] tbl_sym [TABLE_DEPTH];
    int          tbl_fill;
    stub_step_t  stub_step;
    logic [29:0] word_ctr;
    logic [31:0] stub_addr;
    logic [31:0] slot_acc;

    logic [31:0] plt_base;
    logic [7:0]  slot_type;
    logic [23:0] sym_limit;

    initial mismatches = 0;

    // Data-processing immediate: low byte rotated right by twice the rotate field.
    function automatic logic [31:0] arm_imm(input logic [11:0] field);
        logic [31:0] v;
        logic [4:0]  r;
        v = {24'd0, field[7:0]};
        r = {field[11:8], 1'b0};
        if (r == 5'd0)
            return v;
        return (v >> r) | (v << (6'd32 - r));
    endfunction

    function automatic int find_slot(input logic [31:0] off);
        for (int i = 0; i < tbl_fill; i++)
        begin
            if (tbl_off[i] == off)
                return i;
        end
        return -1;
    endfunction

    task automatic resolve_beat(input logic kind, input logic [31:0] off, input logic [31:0] info,
                                input logic [31:0] word, output stub_report_t r);
        int          hit;
        logic [31:0] waddr;
        logic [31:0] target;
        r.status    = apsr_pkg::ST_WORD_CONSUMED;
        r.symbol    = '0;
        r.stub_addr = '0;
        r.slot_off  = '0;
        if (kind != KIND_PLT_WORD)
        begin
            if (info[7:0] != slot_type)
                r.status = apsr_pkg::ST_OTHER_TYPE;
            else if (info[31:8] >= sym_limit)
                r.status = apsr_pkg::ST_OUT_OF_RANGE;
            else
            begin
                hit = find_slot(off);
                if (hit >= 0)
                begin
                    tbl_sym[hit] = info[31:8];
                    r.status     = apsr_pkg::ST_STORED;
                end
                else if (tbl_fill < TABLE_DEPTH)
                begin
                    tbl_off[tbl_fill] = off;
                    tbl_sym[tbl_fill] = info[31:8];
                    tbl_fill++;
                    r.status = apsr_pkg::ST_STORED;
                end
                else
                    r.status = apsr_pkg::ST_TABLE_FULL;
            end
        end
        else
        begin
            waddr    = plt_base + {word_ctr, 2'b00};
            word_ctr = word_ctr + 30'd1;
            case (stub_step)
                SEEK_ADD_PC:
                    if ((word & apsr_pkg::PAT_MASK) == apsr_pkg::PAT_ADD_PC)
                    begin
                        stub_addr = waddr;
                        slot_acc  = arm_imm(word[11:0]) + waddr + apsr_pkg::PC_BIAS;
                        stub_step = SEEK_ADD_IP;
                    end
                SEEK_ADD_IP:
                    if ((word & apsr_pkg::PAT_MASK) == apsr_pkg::PAT_ADD_IP)
                    begin
                        slot_acc  = slot_acc + arm_imm(word[11:0]);
                        stub_step = SEEK_LDR_PC;
                    end
                    else
                        stub_step = SEEK_ADD_PC;
                default:
                begin
                    if ((word & apsr_pkg::PAT_MASK) == apsr_pkg::PAT_LDR_PC)
                    begin
                        target      = slot_acc + {20'd0, word[11:0]};
                        hit         = find_slot(target);
                        r.stub_addr = stub_addr;
                        r.slot_off  = target;
                        if (hit >= 0)
                        begin
                            r.status = apsr_pkg::ST_STUB_FOUND;
                            r.symbol = tbl_sym[hit];
                        end
                        else
                            r.status = apsr_pkg::ST_STUB_UNKNOWN;
                    end
                    stub_step = SEEK_ADD_PC;
                end
            endcase
        end
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (mismatches < 50)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stub_report_t r;
        if (!rst_n)
        begin
            expected_reports.delete();
            tbl_fill        = 0;
            stub_step       = SEEK_ADD_PC;
            word_ctr        = '0;
            stub_addr       = '0;
            slot_acc        = '0;
            plt_base        = '0;
            slot_type       = apsr_pkg::JUMP_SLOT_RESET;
            sym_limit       = '0;
            reports_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    apsr_pkg::CFG_PLT_BASE:     plt_base  = cfg_data;
                    apsr_pkg::CFG_JUMP_SLOT:    slot_type = cfg_data[7:0];
                    apsr_pkg::CFG_SYMBOL_COUNT: sym_limit = cfg_data[23:0];
                    default:                    ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                resolve_beat(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], r);
                expected_reports.push_back(r);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_reports.size() == 0)
                begin
                    if (mismatches < 50)
                        $display("%0t: result beat with nothing expected, status %0d data %h",
                                 $time, m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    r = expected_reports.pop_front();
                    if (m_tuser != r.status)
                        note_mismatch("status", 32'(r.status), 32'(m_tuser));
                    if (m_tdata[23:0] != r.symbol)
                        note_mismatch("symbol_index", 32'(r.symbol), 32'(m_tdata[23:0]));
                    if (m_tdata[55:24] != r.stub_addr)
                        note_mismatch("stub_address", r.stub_addr, m_tdata[55:24]);
                    if (m_tdata[87:56] != r.slot_off)
                        note_mismatch("slot_offset", r.slot_off, m_tdata[87:56]);
                    if (m_tdata[95:88] != 8'd0)
                        note_mismatch("tdata padding", 32'd0, 32'(m_tdata[95:88]));
                end
            end
            reports_pending <= expected_reports.size();
        end
    end

endmodule

FILE: bench/arm_plt_stub_resolver_test.sv
// Top of the PLT stub resolver bench: clock, reset, relocation and PLT word stimulus,
// configuration phases, result back-pressure and the verdict.
// Depends on apsr_pkg, arm_plt_stub_resolver and arm_plt_stub_resolver_checker.
module arm_plt_stub_resolver_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_RELOC      = 1'b0;
    localparam logic KIND_PLT_WORD   = 1'b1;
    localparam int   HOLD_OFF_CYCLES = 600;
    localparam int   STALL_LIMIT     = 4000;
    localparam int   PHASE_BEATS     = 135;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata   = '0;   // reloc_offset[31:0], reloc_info[63:32], instr_word[95:64]
    logic        s_tuser   = 1'b0; // kind[0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [95:0] m_tdata;          // symbol_index[23:0], stub_address[55:24],
                                   // slot_offset[87:56], zero[95:88]
    logic [2:0]  m_tuser;          // status[2:0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    int unsigned check_errors;
    int unsigned reports_pending;

    int          burst_left      = 0;
    int          beats_sent      = 0;
    int          hold_off_asks   = 0;
    int          hold_off_served = 0;
    logic [29:0] plt_words       = '0;
    logic [31:0] cur_base        = '0;
    logic [7:0]  cur_jslot       = apsr_pkg::JUMP_SLOT_RESET;
    logic [23:0] cur_count       = '0;
    logic [31:0] stored_offs[$];

    always #5 clk = ~clk;

    arm_plt_stub_resolver u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    arm_plt_stub_resolver_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (check_errors),
        .reports_pending (reports_pending)
    );

    // Offer one beat; for a relocation, a is the offset and b the info word,
    // for a PLT word, a is the instruction. Unused fields carry random bits.
    task automatic offer_beat(input logic kind, input logic [31:0] a, input logic [31:0] b);
        int gap;
        bit seen;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tuser = kind;
        if (kind == KIND_RELOC)
            s_tdata = {32'($urandom), b, a};
        else
            s_tdata = {a, 32'($urandom), 32'($urandom)};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        burst_left--;
        beats_sent++;
        if (kind == KIND_PLT_WORD)
            plt_words = plt_words + 30'd1;
        else if (b[7:0] == cur_jslot && b[31:8] < cur_count &&
                 stored_offs.size() < apsr_pkg::TABLE_DEPTH_DEF)
        begin
            seen = 0;
            foreach (stored_offs[i])
            begin
                if (stored_offs[i] == a)
                    seen = 1;
            end
            if (!seen)
                stored_offs.push_back(a);
        end
    endtask

    task automatic write_reg(input apsr_pkg::cfg_idx_t idx, input logic [31:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        case (idx)
            apsr_pkg::CFG_PLT_BASE:  cur_base  = val;
            apsr_pkg::CFG_JUMP_SLOT: cur_jslot = val[7:0];
            default:                 cur_count = val[23:0];
        endcase
    endtask

    task automatic drain(input int extra);
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (reports_pending != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic send_random_reloc();
        int          pick;
        logic [31:0] off;
        logic [23:0] sym;
        logic [7:0]  typ;
        pick = $urandom_range(0, 99);
        typ  = cur_jslot;
        sym  = (cur_count == 0) ? 24'($urandom) : 24'($urandom_range(0, cur_count - 1));
        if (stored_offs.size() > 0 && $urandom_range(0, 99) < 40)
            off = stored_offs[$urandom_range(0, stored_offs.size() - 1)];
        else if ($urandom_range(0, 99) < 70)
            off = cur_base + $urandom_range(0, 32'h00ff_ffff);
        else
            off = $urandom;
        if (pick < 20)
            typ = cur_jslot ^ 8'($urandom_range(1, 255));
        else if (pick < 35)
            sym = 24'($urandom_range(cur_count, 24'hff_ffff));
        offer_beat(KIND_RELOC, off, {sym, typ});
    endtask

    // Encode a three-word stub aimed at target: bits 27..20 and 19..12 go in the two
    // rotated immediates, bits 11..0 in the load. Scramble replaces all immediates.
    task automatic send_stub(input logic [31:0] target, input bit scramble);
        logic [31:0] d;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        d  = target - (cur_base + {plt_words, 2'b00} + apsr_pkg::PC_BIAS);
        w0 = apsr_pkg::PAT_ADD_PC | {20'd0, 4'd6, d[27:20]};
        w1 = apsr_pkg::PAT_ADD_IP | {20'd0, 4'd10, d[19:12]};
        w2 = apsr_pkg::PAT_LDR_PC | {20'd0, d[11:0]};
        if (scramble)
        begin
            w0[11:0] = 12'($urandom);
            w1[11:0] = 12'($urandom);
            w2[11:0] = 12'($urandom);
        end
        offer_beat(KIND_PLT_WORD, w0, 32'd0);
        if ($urandom_range(0, 9) == 0)
            send_random_reloc();
        offer_beat(KIND_PLT_WORD, w1, 32'd0);
        if ($urandom_range(0, 9) == 0)
            send_random_reloc();
        offer_beat(KIND_PLT_WORD, w2, 32'd0);
    endtask

    initial
    begin : result_sink
        int seg;
        int mode;
        int period;
        int k;
        seg    = 0;
        mode   = 0;
        period = 1;
        k      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_served != hold_off_asks)
            begin
                // hold off long enough for the block to back up into its input
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                hold_off_served++;
            end
            else
            begin
                if (seg == 0)
                begin
                    seg    = $urandom_range(20, 200);
                    mode   = $urandom_range(0, 3);
                    period = $urandom_range(2, 5);
                end
                seg--;
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = ($urandom_range(0, 99) < 70);
                    2:       m_tready = ($urandom_range(0, 99) < 25);
                    default: m_tready = (k % period == 0);
                endcase
                k++;
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int          pick;
        int          phase_end;
        logic [31:0] base;
        logic [31:0] word;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_reg(apsr_pkg::CFG_PLT_BASE, 32'h0001_0000);
        write_reg(apsr_pkg::CFG_JUMP_SLOT, 32'(apsr_pkg::JUMP_SLOT_RESET));
        write_reg(apsr_pkg::CFG_SYMBOL_COUNT, 32'h0000_1000);

        offer_beat(KIND_RELOC, 32'h0001_2000, {24'd5, 8'd21});
        offer_beat(KIND_RELOC, 32'h0001_2000, {24'h00_1000, 8'd22});
        offer_beat(KIND_RELOC, 32'h0001_2000, {24'h00_0fff, 8'd22});
        offer_beat(KIND_RELOC, 32'h0001_2000, {24'd7, 8'd22});
        offer_beat(KIND_RELOC, 32'hffff_ffff, {24'd0, 8'd22});
        offer_beat(KIND_RELOC, 32'h0000_0000, 32'h0000_0000);
        offer_beat(KIND_RELOC, 32'hffff_ffff, 32'hffff_ffff);
        // target of the unrotated stub below: first word address + 8 + 0x80 + 0x40 + 0x123
        offer_beat(KIND_RELOC, 32'h0001_0000 + 32'd8 + 32'h80 + 32'h40 + 32'h123,
                   {24'h00_0abc, 8'd22});
        offer_beat(KIND_PLT_WORD, apsr_pkg::PAT_ADD_PC | 32'h080, 32'd0);
        offer_beat(KIND_PLT_WORD, apsr_pkg::PAT_ADD_IP | 32'h040, 32'd0);
        offer_beat(KIND_PLT_WORD, apsr_pkg::PAT_LDR_PC | 32'h123, 32'd0);
        send_stub(32'h0001_2000, 1'b0);
        offer_beat(KIND_PLT_WORD, apsr_pkg::PAT_ADD_PC | 32'hfff, 32'd0);
        offer_beat(KIND_PLT_WORD, apsr_pkg::PAT_ADD_IP | 32'hfff, 32'd0);
        offer_beat(KIND_PLT_WORD, apsr_pkg::PAT_LDR_PC | 32'hfff, 32'd0);
        // second add-pc breaks the match and is not taken as a new start
        offer_beat(KIND_PLT_WORD, apsr_pkg::PAT_ADD_PC | 32'h010, 32'd0);
        offer_beat(KIND_PLT_WORD, apsr_pkg::PAT_ADD_PC | 32'h020, 32'd0);
        offer_beat(KIND_PLT_WORD, apsr_pkg::PAT_ADD_IP | 32'h030, 32'd0);
        offer_beat(KIND_PLT_WORD, apsr_pkg::PAT_LDR_PC | 32'h040, 32'd0);
        offer_beat(KIND_PLT_WORD, apsr_pkg::PAT_ADD_PC | 32'h5a5, 32'd0);
        offer_beat(KIND_PLT_WORD, apsr_pkg::PAT_ADD_IP | 32'ha5a, 32'd0);
        offer_beat(KIND_PLT_WORD, 32'h0000_0000, 32'd0);
        offer_beat(KIND_PLT_WORD, 32'hffff_ffff, 32'd0);

        for (int phase = 0; phase < 8; phase++)
        begin
            drain(4);
            case (phase % 4)
                0:       base = 32'h0000_0000;
                1:       base = 32'hffff_ffff;
                2:       base = $urandom;
                default: base = 32'h0001_0000;
            endcase
            write_reg(apsr_pkg::CFG_PLT_BASE, base);
            case ((phase + 1) % 4)
                0:       write_reg(apsr_pkg::CFG_JUMP_SLOT, 32'(apsr_pkg::JUMP_SLOT_RESET));
                1:       write_reg(apsr_pkg::CFG_JUMP_SLOT, 32'd0);
                2:       write_reg(apsr_pkg::CFG_JUMP_SLOT, 32'd255);
                default: write_reg(apsr_pkg::CFG_JUMP_SLOT, $urandom_range(0, 255));
            endcase
            case (phase % 5)
                0:       write_reg(apsr_pkg::CFG_SYMBOL_COUNT, 32'h0000_1000);
                1:       write_reg(apsr_pkg::CFG_SYMBOL_COUNT, 32'h00ff_ffff);
                2:       write_reg(apsr_pkg::CFG_SYMBOL_COUNT, 32'd0);
                3:       write_reg(apsr_pkg::CFG_SYMBOL_COUNT, 32'd1);
                default: write_reg(apsr_pkg::CFG_SYMBOL_COUNT, $urandom_range(0, 32'h00ff_ffff));
            endcase
            if (phase == 2)
                hold_off_asks++;
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    send_random_reloc();
                else if (pick < 60 && stored_offs.size() > 0)
                    send_stub(stored_offs[$urandom_range(0, stored_offs.size() - 1)], 1'b0);
                else if (pick < 70)
                    send_stub(cur_base + $urandom_range(0, 32'h00ff_ffff), 1'b0);
                else if (pick < 78)
                    send_stub($urandom, 1'b1);
                else if (pick < 88)
                begin
                    // broken stub: one or two good words, then a breaker
                    offer_beat(KIND_PLT_WORD,
                               apsr_pkg::PAT_ADD_PC | 32'($urandom_range(0, 12'hfff)), 32'd0);
                    if ($urandom_range(0, 1))
                        offer_beat(KIND_PLT_WORD,
                                   apsr_pkg::PAT_ADD_IP | 32'($urandom_range(0, 12'hfff)),
                                   32'd0);
                    word = $urandom_range(0, 1)
                         ? 32'($urandom)
                         : apsr_pkg::PAT_ADD_PC | 32'($urandom_range(0, 12'hfff));
                    offer_beat(KIND_PLT_WORD, word, 32'd0);
                end
                else
                begin
                    case ($urandom_range(0, 5))
                        0:       word = 32'h0000_0000;
                        1:       word = 32'hffff_ffff;
                        2:       word = apsr_pkg::PAT_ADD_IP | 32'($urandom_range(0, 12'hfff));
                        3:       word = apsr_pkg::PAT_LDR_PC | 32'($urandom_range(0, 12'hfff));
                        4:       word = apsr_pkg::PAT_ADD_PC | 32'($urandom_range(0, 12'hfff));
                        default: word = $urandom;
                    endcase
                    offer_beat(KIND_PLT_WORD, word, 32'd0);
                end
            end
        end

        drain(100);
        if (check_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
